FILE: hdl/bmls_pkg.sv
// ----------------------------------------------------------------------------
// bmls_pkg
// Shared types and constants for the byte memory load/store block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmls_pkg;

  localparam int ADDR_BITS_DEF = 20;
  localparam int LANES = 4;
  localparam int LANE_BITS = 2;

  localparam logic [3:0] LATENCY_RESET = 4'd3;

  localparam logic [2:0] MODE_LOAD_S = 3'd0;
  localparam logic [2:0] MODE_LOAD_U = 3'd1;
  localparam logic [2:0] MODE_STORE  = 3'd2;
  localparam logic [2:0] MODE_START  = 3'd3;
  localparam logic [2:0] MODE_TICK   = 3'd4;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [19:0] address;
    logic [1:0]  size;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        busy_res;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/bmls_lane_ram.sv
// ----------------------------------------------------------------------------
// bmls_lane_ram
// One byte lane of the data memory: single port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmls_lane_ram #(
  parameter int ROW_BITS = bmls_pkg::ADDR_BITS_DEF - bmls_pkg::LANE_BITS
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic                we,
  input  wire logic [ROW_BITS-1:0] addr,
  input  wire logic [7:0]          wdata,
  output logic      [7:0]          rdata
);

  logic [7:0] mem_r [2**ROW_BITS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/byte_memory_load_store.sv
// ----------------------------------------------------------------------------
// byte_memory_load_store
// Byte-addressed little-endian data memory in four byte-lane banks, with
// signed and unsigned loads, stores of 1, 2 or 4 bytes and a busy countdown.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   bmls_pkg::in_item_t
//   out_     output     out_valid/out_stall bmls_pkg::out_item_t
//   cfg_     input      cfg_valid/cfg_ready access_latency (4 bits)
//
// One item per cycle while in_stall is low; a result passes the lane bank
// read register, then the output register.
// Every access touches each lane bank at most once, so misaligned words need
// no second access. Memory contents are not cleared by reset.
// Reset clears the countdown, the pipeline valids and loads access_latency 3.
// A stalled output holds the stage behind it; in_stall rises only when both
// are full.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_memory_load_store #(
  parameter int ADDR_BITS = bmls_pkg::ADDR_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bmls_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bmls_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [3:0]          cfg_data
);

  localparam int ROW_BITS = ADDR_BITS - bmls_pkg::LANE_BITS;

  logic                 accept;
  logic                 adv;
  logic [ADDR_BITS-1:0] addr;
  logic [ROW_BITS-1:0]  row;
  logic [ROW_BITS-1:0]  row_p1;
  logic [1:0]           off;

  logic [ROW_BITS-1:0]  lane_addr [bmls_pkg::LANES];
  logic [7:0]           lane_wdata [bmls_pkg::LANES];
  logic                 lane_we [bmls_pkg::LANES];
  logic [7:0]           lane_q [bmls_pkg::LANES];

  logic       v1_r, v1_nxt;
  logic [2:0] mode1_r;
  logic [1:0] size1_r;
  logic [1:0] off1_r;
  logic       busy1_r;

  logic       busy_r, busy_nxt;
  logic [3:0] count_r, count_nxt;
  logic [3:0] lat_r;

  logic                out_valid_r, out_valid_nxt;
  bmls_pkg::out_item_t out_r, out_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = v1_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign addr   = ADDR_BITS'(in_data.address);
  assign row    = addr[ADDR_BITS-1:bmls_pkg::LANE_BITS];
  assign off    = addr[1:0];
  assign row_p1 = row + ROW_BITS'(1);

  // lane l carries byte (l - off) of the access
  always_comb begin
    logic [1:0] idx;
    logic       used;
    for (int l = 0; l < bmls_pkg::LANES; l++) begin
      idx = 2'(l) - off;
      case (in_data.size)
        bmls_pkg::SIZE_BYTE: used = (idx == 2'd0);
        bmls_pkg::SIZE_HALF: used = (idx <= 2'd1);
        default:             used = 1'b1;
      endcase
      lane_addr[l]  = (2'(l) >= off) ? row : row_p1;
      lane_wdata[l] = in_data.write_data[8*idx +: 8];
      lane_we[l]    = accept && used && (in_data.mode == bmls_pkg::MODE_STORE);
    end
  end

  for (genvar g = 0; g < bmls_pkg::LANES; g++) begin : g_lane
    bmls_lane_ram #(
      .ROW_BITS(ROW_BITS)
    ) u_ram (
      .clk  (clk),
      .en   (accept),
      .we   (lane_we[g]),
      .addr (lane_addr[g]),
      .wdata(lane_wdata[g]),
      .rdata(lane_q[g])
    );
  end

  // countdown
  always_comb begin
    busy_nxt  = busy_r;
    count_nxt = count_r;
    if (accept) begin
      case (in_data.mode)
        bmls_pkg::MODE_START: begin
          busy_nxt  = 1'b1;
          count_nxt = lat_r;
        end
        bmls_pkg::MODE_TICK: begin
          if (busy_r) begin
            if (count_r != 4'd0) begin
              count_nxt = count_r - 4'd1;
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      v1_nxt = 1'b1;
    end else if (adv) begin
      v1_nxt = 1'b0;
    end else begin
      v1_nxt = v1_r;
    end
    out_valid_nxt = adv ? v1_r : out_valid_r;
  end

  // byte gather and extension
  always_comb begin
    logic [7:0]  b [bmls_pkg::LANES];
    logic [31:0] val;
    for (int i = 0; i < bmls_pkg::LANES; i++) begin
      b[i] = lane_q[2'(off1_r + 2'(i))];
    end
    case (size1_r)
      bmls_pkg::SIZE_BYTE: begin
        val = {{24{(mode1_r == bmls_pkg::MODE_LOAD_S) && b[0][7]}}, b[0]};
      end
      bmls_pkg::SIZE_HALF: begin
        val = {{16{(mode1_r == bmls_pkg::MODE_LOAD_S) && b[1][7]}}, b[1], b[0]};
      end
      default: val = {b[3], b[2], b[1], b[0]};
    endcase
    out_nxt.read_data = (mode1_r == bmls_pkg::MODE_LOAD_S ||
                         mode1_r == bmls_pkg::MODE_LOAD_U) ? val : 32'd0;
    out_nxt.busy_res  = busy1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      count_r     <= 4'd0;
      lat_r       <= bmls_pkg::LATENCY_RESET;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        lat_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode1_r <= in_data.mode;
      size1_r <= in_data.size;
      off1_r  <= off;
      busy1_r <= busy_nxt;
    end
    if (adv && v1_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hdl/bmls_checker.sv
// ----------------------------------------------------------------------------
// bmls_checker
// Port-level checks for byte_memory_load_store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmls_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire bmls_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

bind byte_memory_load_store bmls_checker u_bmls_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

FILE: tb/sv/byte_memory_load_store_test.sv
// ----------------------------------------------------------------------------
// byte_memory_load_store_test
// Self-checking bench for the byte memory load/store block. A shadow copy of
// the byte memory and of the busy countdown predicts every result. Directed
// accesses cover sign and zero extension, odd sizes, misaligned and wrapping
// addresses, spare modes and countdown restarts. Random phases then run under
// several access latencies with random gaps, stalls and one long output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_memory_load_store_test;

  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_WIDE = 2'd3;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam int unsigned PHASE_ITEMS = 470;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  bmls_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_stall;
  bmls_pkg::out_item_t  out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [3:0]           cfg_data;

  byte_memory_load_store u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow state
  bit [7:0]    shadow_mem [bit [19:0]];
  bit [19:0]   written_addrs [$];
  logic        busy_now;
  logic [3:0]  count_now;
  logic [3:0]  latency_now;
  logic [19:0] hot_base;

  bmls_pkg::out_item_t awaited_replies [$];
  int          errors;
  bit          steady;
  int          hold_request;
  int          n_loads, n_stores, n_starts, n_ticks, n_spare, n_clears;
  logic [3:0]  mid_latency;

  function automatic int unsigned width_of(input logic [1:0] size);
    if (size == bmls_pkg::SIZE_BYTE) return 1;
    if (size == bmls_pkg::SIZE_HALF) return 2;
    return 4;
  endfunction

  function automatic bit span_written(input logic [19:0] a, input int unsigned n);
    for (int i = 0; i < n; i++)
      if (!shadow_mem.exists(a + 20'(i))) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bmls_pkg::out_item_t predict_access(input bmls_pkg::in_item_t it);
    bmls_pkg::out_item_t r;
    int unsigned nb;
    logic [31:0] raw;
    logic [19:0] a;
    r = '0;
    raw = '0;
    nb = width_of(it.size);
    case (it.mode)
      bmls_pkg::MODE_LOAD_S, bmls_pkg::MODE_LOAD_U: begin
        n_loads++;
        for (int i = 0; i < nb; i++)
          raw |= 32'(shadow_mem[it.address + 20'(i)]) << (8 * i);
        if (it.mode == bmls_pkg::MODE_LOAD_S && nb == 1) raw = {{24{raw[7]}}, raw[7:0]};
        if (it.mode == bmls_pkg::MODE_LOAD_S && nb == 2) raw = {{16{raw[15]}}, raw[15:0]};
        r.read_data = raw;
      end
      bmls_pkg::MODE_STORE: begin
        n_stores++;
        for (int i = 0; i < nb; i++) begin
          a = it.address + 20'(i);
          if (!shadow_mem.exists(a)) written_addrs.push_back(a);
          shadow_mem[a] = 8'(it.write_data >> (8 * i));
        end
      end
      bmls_pkg::MODE_START: begin
        n_starts++;
        busy_now = 1'b1;
        count_now = latency_now;
      end
      bmls_pkg::MODE_TICK: begin
        n_ticks++;
        if (busy_now) begin
          if (count_now != 0) count_now = count_now - 4'd1;
          else begin
            busy_now = 1'b0;
            n_clears++;
          end
        end
      end
      default: n_spare++;
    endcase
    r.busy_res = busy_now;
    return r;
  endfunction

  function automatic logic [19:0] store_target();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 20'($urandom);
    if (r < 45) return 20'($urandom_range(255));
    if (r < 70) return 20'hFFF80 + 20'($urandom_range(255));
    return hot_base + 20'($urandom_range(255));
  endfunction

  function automatic logic [1:0] fit_size(input logic [19:0] a, input logic [1:0] s);
    logic [1:0] r;
    r = s;
    if (r >= SIZE_WORD && !span_written(a, 4)) r = bmls_pkg::SIZE_HALF;
    if (r == bmls_pkg::SIZE_HALF && !span_written(a, 2)) r = bmls_pkg::SIZE_BYTE;
    return r;
  endfunction

  function automatic bmls_pkg::in_item_t random_access();
    bmls_pkg::in_item_t it;
    int unsigned pick;
    int unsigned start_cut;
    it.mode = bmls_pkg::MODE_TICK;
    it.address = 20'($urandom);
    it.size = 2'($urandom_range(3));
    it.write_data = $urandom;
    start_cut = busy_now ? 2 : 10;
    pick = $urandom_range(99);
    if (pick < 28 || (pick < 56 && written_addrs.size() == 0)) begin
      it.mode = bmls_pkg::MODE_STORE;
      it.address = store_target();
    end else if (pick < 56) begin
      it.mode = (pick < 42) ? bmls_pkg::MODE_LOAD_S : bmls_pkg::MODE_LOAD_U;
      it.address = written_addrs[$urandom_range(written_addrs.size() - 1)];
      it.size = fit_size(it.address, it.size);
    end else if (pick < 56 + start_cut) begin
      it.mode = bmls_pkg::MODE_START;
    end else if (pick >= 97) begin
      it.mode = MODE_SPARE_LO + 3'($urandom_range(2));
    end
    return it;
  endfunction

  function automatic bmls_pkg::in_item_t make_access(input logic [2:0] mode,
                                                     input logic [19:0] a,
                                                     input logic [1:0] size,
                                                     input logic [31:0] d);
    bmls_pkg::in_item_t it;
    it.mode = mode;
    it.address = a;
    it.size = size;
    it.write_data = d;
    return it;
  endfunction

  // one transfer on the input channel, valid left high for the next call
  task automatic send_access(input bmls_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    awaited_replies.push_back(predict_access(it));
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_latency(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    latency_now = v;
  endtask

  task automatic run_random_phase(input int unsigned count);
    for (int k = 0; k < count; k++) send_access(random_access());
  endtask

  task automatic test_countdown_basics();
    send_access(make_access(bmls_pkg::MODE_TICK, '0, bmls_pkg::SIZE_BYTE, '0));
    send_access(make_access(bmls_pkg::MODE_START, '0, bmls_pkg::SIZE_BYTE, '0));
    repeat (2) send_access(make_access(bmls_pkg::MODE_TICK, '0, bmls_pkg::SIZE_BYTE, '0));
    send_access(make_access(bmls_pkg::MODE_START, '0, bmls_pkg::SIZE_BYTE, '0));
    repeat (5) send_access(make_access(bmls_pkg::MODE_TICK, '0, bmls_pkg::SIZE_BYTE, '0));
  endtask

  task automatic test_access_edges();
    send_access(make_access(bmls_pkg::MODE_STORE, 20'h00000, SIZE_WORD, 32'h80FF7F01));
    send_access(make_access(bmls_pkg::MODE_STORE, 20'h00004, bmls_pkg::SIZE_BYTE,
                            32'h00000000));
    send_access(make_access(bmls_pkg::MODE_LOAD_S, 20'h00003, bmls_pkg::SIZE_BYTE, '0));
    send_access(make_access(bmls_pkg::MODE_LOAD_U, 20'h00003, bmls_pkg::SIZE_BYTE, '0));
    send_access(make_access(bmls_pkg::MODE_LOAD_S, 20'h00002, bmls_pkg::SIZE_HALF, '0));
    send_access(make_access(bmls_pkg::MODE_LOAD_U, 20'h00001, bmls_pkg::SIZE_HALF, '0));
    send_access(make_access(bmls_pkg::MODE_LOAD_S, 20'h00001, SIZE_WIDE, '0));
    send_access(make_access(bmls_pkg::MODE_STORE, 20'hFFFFE, SIZE_WIDE, 32'hFFFFFFFF));
    send_access(make_access(bmls_pkg::MODE_LOAD_U, 20'hFFFFE, SIZE_WORD, '0));
    send_access(make_access(bmls_pkg::MODE_LOAD_S, 20'hFFFFF, bmls_pkg::SIZE_HALF, '0));
    send_access(make_access(bmls_pkg::MODE_STORE, 20'hFFFFD, bmls_pkg::SIZE_HALF,
                            32'h12345678));
    send_access(make_access(bmls_pkg::MODE_LOAD_U, 20'hFFFFD, SIZE_WORD, '0));
    for (int m = 0; m < 3; m++)
      send_access(make_access(MODE_SPARE_LO + 3'(m), 20'hFFFFF, SIZE_WIDE, 32'hFFFFFFFF));
  endtask

  task automatic test_random_default();
    run_random_phase(PHASE_ITEMS);
    drain_replies();
  endtask

  task automatic test_latency_zero();
    write_latency(4'd0);
    run_random_phase(PHASE_ITEMS);
    drain_replies();
  endtask

  task automatic test_latency_max_steady();
    write_latency(4'd15);
    steady = 1'b1;
    run_random_phase(PHASE_ITEMS);
    steady = 1'b0;
    drain_replies();
  endtask

  task automatic test_latency_mid();
    mid_latency = 4'($urandom_range(14, 1));
    write_latency(mid_latency);
    run_random_phase(PHASE_ITEMS);
    drain_replies();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_hold();
    hold_request = 60;
    run_random_phase(40);
    drain_replies();
  endtask

  always @(posedge clk) begin : reply_check
    bmls_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = awaited_replies.pop_front();
        if (out_data.read_data !== want.read_data) begin
          errors++;
          $display("%0t: read_data mismatch, expected %h, actual %h",
                   $time, want.read_data, out_data.read_data);
        end
        if (out_data.busy_res !== want.busy_res) begin
          errors++;
          $display("%0t: busy_res mismatch, expected %b, actual %b",
                   $time, want.busy_res, out_data.busy_res);
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 7);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    errors = 0;
    steady = 1'b0;
    hold_request = 0;
    busy_now = 1'b0;
    count_now = '0;
    latency_now = bmls_pkg::LATENCY_RESET;
    hot_base = 20'($urandom);
    mid_latency = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_countdown_basics();
    test_access_edges();
    test_random_default();
    test_latency_zero();
    test_output_hold();
    test_latency_max_steady();
    test_latency_mid();

    drain_replies();
    repeat (10) @(posedge clk);
    $display("covered %0d loads, %0d stores, %0d starts, %0d ticks, %0d spare-mode items",
             n_loads, n_stores, n_starts, n_ticks, n_spare);
    $display("countdown cleared %0d times under latencies 3, 0, 15 and %0d",
             n_clears, mid_latency);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

FILE: byte_memory_load_store.f
hdl/bmls_pkg.sv
hdl/bmls_lane_ram.sv
hdl/byte_memory_load_store.sv
hdl/bmls_checker.sv
tb/sv/byte_memory_load_store_test.sv
